### sv/pns_pkg.sv
// ---------------------------------------------------------------------------
// pns_pkg
// Shared types, constants and the fixed colour palette of the scaler.
// ---------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

    localparam int COORD_W  = 9;
    localparam int PIX_W    = 8;
    localparam int IDX_W    = 6;
    localparam int COLOUR_W = 16;
    localparam int S_DATA_W = 32;

    localparam int SRC_W_DEF = 256;
    localparam int SRC_H_DEF = 240;
    localparam int DST_W_DEF = 480;
    localparam int DST_H_DEF = 320;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // control of one item leaving the coordinate pipeline
    typedef struct packed {
        logic valid;
        logic mode;
        logic keep;
    } pns_ctl_t;

    localparam logic [23:0] RGB888 [64] = '{
        24'h666666, 24'h002A88, 24'h1412A7, 24'h3B00A4,
        24'h5C007E, 24'h6E0040, 24'h6C0600, 24'h561D00,
        24'h333500, 24'h0B4800, 24'h005200, 24'h004F08,
        24'h00404D, 24'h000000, 24'h000000, 24'h000000,
        24'hADADAD, 24'h155FD9, 24'h4240FF, 24'h7527FE,
        24'hA01ACC, 24'hB71E7B, 24'hB53120, 24'h994E00,
        24'h6B6D00, 24'h388700, 24'h0C9300, 24'h008F32,
        24'h007C8D, 24'h000000, 24'h000000, 24'h000000,
        24'hFFFEFF, 24'h64B0FF, 24'h9290FF, 24'hC676FF,
        24'hF36AFF, 24'hFF6ECC, 24'hFF8170, 24'hEA9E22,
        24'hBCBE00, 24'h88D800, 24'h5CE430, 24'h45E082,
        24'h48CDDE, 24'h4F4F4F, 24'h000000, 24'h000000,
        24'hFFFEFF, 24'hC0DFFF, 24'hD3D2FF, 24'hE8C8FF,
        24'hFBC2FF, 24'hFEC4EA, 24'hFECCC5, 24'hF7D8A5,
        24'hE4E594, 24'hCFEF96, 24'hBDF4AB, 24'hB3F3CC,
        24'hB5EBF2, 24'hB8B8B8, 24'h000000, 24'h000000
    };

    function automatic logic [COLOUR_W-1:0] to_rgb565(input logic [IDX_W-1:0] idx);
        logic [23:0] c;
        c = RGB888[idx];
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

`default_nettype wire

### sv/pns_ram.sv
// ---------------------------------------------------------------------------
// pns_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pns_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/pns_map.sv
// ---------------------------------------------------------------------------
// pns_map
// Coordinate pipeline: range and border checks, nearest-neighbour mapping
// by reciprocal multiply with one correction step, frame-store address.
// ---------------------------------------------------------------------------
`default_nettype none

module pns_map #(
    parameter int SRC_W  = pns_pkg::SRC_W_DEF,
    parameter int SRC_H  = pns_pkg::SRC_H_DEF,
    parameter int DST_W  = pns_pkg::DST_W_DEF,
    parameter int DST_H  = pns_pkg::DST_H_DEF,
    parameter int ADDR_W = $clog2(SRC_W * SRC_H)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic                         in_mode,
    input  wire logic [pns_pkg::COORD_W-1:0]  in_x,
    input  wire logic [pns_pkg::COORD_W-1:0]  in_y,
    input  wire logic [pns_pkg::PIX_W-1:0]    in_pix,
    output pns_pkg::pns_ctl_t                 out_ctl,
    output logic      [ADDR_W-1:0]            out_addr,
    output logic      [pns_pkg::IDX_W-1:0]    out_idx
);

    import pns_pkg::*;

    localparam int SCALE_W = SRC_W * DST_H / SRC_H;
    localparam int OFF_X   = (SCALE_W < DST_W) ? (DST_W - SCALE_W) / 2 : 0;
    localparam int SCALE_D = (SCALE_W == 0) ? 1 : SCALE_W;
    localparam int SXW     = $clog2(SRC_W);
    localparam int SYW     = $clog2(SRC_H);
    localparam int NXW     = COORD_W + SXW;
    localparam int NYW     = COORD_W + SYW;
    localparam int MX      = (2 ** NXW) / SCALE_D;
    localparam int MY      = (2 ** NYW) / DST_H;
    localparam int DXW     = $clog2(SCALE_D + 1);
    localparam int DYW     = $clog2(DST_H + 1);
    localparam int PXW     = 2 * NXW + 1;
    localparam int PYW     = 2 * NYW + 1;

    // stage a: captured item
    logic               a_valid_reg, a_mode_reg;
    logic [COORD_W-1:0] a_x_reg, a_y_reg;
    logic [PIX_W-1:0]   a_pix_reg;

    // stage b: numerators
    logic               b_valid_reg, b_mode_reg, b_keep_reg;
    logic [NXW-1:0]     b_nx_reg;
    logic [NYW-1:0]     b_ny_reg;
    logic [SXW-1:0]     b_wx_reg;
    logic [SYW-1:0]     b_wy_reg;
    logic [IDX_W-1:0]   b_idx_reg;

    // stage c: quotient estimates
    logic               c_valid_reg, c_mode_reg, c_keep_reg;
    logic [NXW-1:0]     c_nx_reg, c_qx_reg;
    logic [NYW-1:0]     c_ny_reg, c_qy_reg;
    logic [SXW-1:0]     c_wx_reg;
    logic [SYW-1:0]     c_wy_reg;
    logic [IDX_W-1:0]   c_idx_reg;

    // stage d: source coordinates
    logic               d_valid_reg, d_mode_reg, d_keep_reg;
    logic [SXW-1:0]     d_sx_reg;
    logic [SYW-1:0]     d_sy_reg;
    logic [IDX_W-1:0]   d_idx_reg;

    // stage e: address
    logic               e_valid_reg, e_mode_reg, e_keep_reg;
    logic [ADDR_W-1:0]  e_addr_reg;
    logic [IDX_W-1:0]   e_idx_reg;

    logic [31:0]        xe, ye;
    logic               rd_zero, wr_ok;
    logic [COORD_W-1:0] ox, oy;
    logic [PXW-1:0]     prod_x;
    logic [PYW-1:0]     prod_y;
    logic [NXW-1:0]     qd_x, rem_x, q_x;
    logic [NYW-1:0]     qd_y, rem_y, q_y;
    logic               bump_x, bump_y;

    always_comb begin
        xe      = 32'(a_x_reg);
        ye      = 32'(a_y_reg);
        rd_zero = (xe >= 32'(DST_W)) || (ye >= 32'(DST_H)) || (SCALE_W == 0)
                  || (xe < 32'(OFF_X)) || ((xe - 32'(OFF_X)) >= 32'(SCALE_W));
        wr_ok   = (xe < 32'(SRC_W)) && (ye < 32'(SRC_H));
        ox      = rd_zero ? '0 : COORD_W'(xe - 32'(OFF_X));
        oy      = rd_zero ? '0 : a_y_reg;
    end

    assign prod_x = PXW'(b_nx_reg) * PXW'(MX);
    assign prod_y = PYW'(b_ny_reg) * PYW'(MY);

    always_comb begin
        qd_x   = NXW'((NXW + DXW)'(c_qx_reg) * (NXW + DXW)'(SCALE_D));
        rem_x  = c_nx_reg - qd_x;
        bump_x = (NXW + DXW)'(rem_x) >= (NXW + DXW)'(SCALE_D);
        q_x    = c_qx_reg + NXW'(bump_x);
        qd_y   = NYW'((NYW + DYW)'(c_qy_reg) * (NYW + DYW)'(DST_H));
        rem_y  = c_ny_reg - qd_y;
        bump_y = (NYW + DYW)'(rem_y) >= (NYW + DYW)'(DST_H);
        q_y    = c_qy_reg + NYW'(bump_y);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mode_reg <= in_mode;
            a_x_reg    <= in_x;
            a_y_reg    <= in_y;
            a_pix_reg  <= in_pix;

            b_mode_reg <= a_mode_reg;
            b_keep_reg <= (a_mode_reg == MODE_READ) ? !rd_zero : wr_ok;
            b_nx_reg   <= NXW'(NXW'(ox) * NXW'(SRC_W));
            b_ny_reg   <= NYW'(NYW'(oy) * NYW'(SRC_H));
            b_wx_reg   <= SXW'(a_x_reg);
            b_wy_reg   <= SYW'(a_y_reg);
            b_idx_reg  <= a_pix_reg[IDX_W-1:0];

            c_mode_reg <= b_mode_reg;
            c_keep_reg <= b_keep_reg;
            c_nx_reg   <= b_nx_reg;
            c_ny_reg   <= b_ny_reg;
            c_qx_reg   <= prod_x[NXW +: NXW];
            c_qy_reg   <= prod_y[NYW +: NYW];
            c_wx_reg   <= b_wx_reg;
            c_wy_reg   <= b_wy_reg;
            c_idx_reg  <= b_idx_reg;

            d_mode_reg <= c_mode_reg;
            d_keep_reg <= c_keep_reg;
            d_sx_reg   <= (c_mode_reg == MODE_READ) ? SXW'(q_x) : c_wx_reg;
            d_sy_reg   <= (c_mode_reg == MODE_READ) ? SYW'(q_y) : c_wy_reg;
            d_idx_reg  <= c_idx_reg;

            e_mode_reg <= d_mode_reg;
            e_keep_reg <= d_keep_reg;
            e_addr_reg <= ADDR_W'(ADDR_W'(d_sy_reg) * ADDR_W'(SRC_W)) + ADDR_W'(d_sx_reg);
            e_idx_reg  <= d_idx_reg;
        end
    end

    assign out_ctl.valid = e_valid_reg;
    assign out_ctl.mode  = e_mode_reg;
    assign out_ctl.keep  = e_keep_reg;
    assign out_addr      = e_addr_reg;
    assign out_idx       = e_idx_reg;

endmodule

`default_nettype wire

### sv/palette_nearest_scaler.sv
// ---------------------------------------------------------------------------
// palette_nearest_scaler
// Palette-indexed frame store with nearest-neighbour scaled RGB565 read-out.
//
//   channel  dir  tdata                                  tuser
//   s_       in   x_coord, y_coord, pixel_index          mode
//   m_       out  colour                                 -
//
// one item per clock while the output is not stalled; a read passes stages a to e
// of the coordinate pipeline, the frame-store read port and the output register
// writes give no item; a later read always sees an earlier write
// no clearing pass after reset: the frame store is undefined until written
// the whole pipeline halts while the output register is full and m_tready is low
// ---------------------------------------------------------------------------
`default_nettype none

module palette_nearest_scaler #(
    parameter int SRC_W = pns_pkg::SRC_W_DEF,
    parameter int SRC_H = pns_pkg::SRC_H_DEF,
    parameter int DST_W = pns_pkg::DST_W_DEF,
    parameter int DST_H = pns_pkg::DST_H_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pns_pkg::S_DATA_W-1:0]  s_tdata,  // x_coord, y_coord, pixel_index
    input  wire logic                          s_tuser,  // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pns_pkg::COLOUR_W-1:0]  m_tdata   // colour
);

    import pns_pkg::*;

    localparam int DEPTH  = SRC_W * SRC_H;
    localparam int ADDR_W = $clog2(DEPTH);

    pns_ctl_t              e_ctl;
    logic [ADDR_W-1:0]     e_addr;
    logic [IDX_W-1:0]      e_idx;
    logic [IDX_W-1:0]      ram_rdata;
    logic                  adv, ram_we, ram_re;
    logic                  f_valid_reg, f_zero_reg;
    logic                  out_valid_reg;
    logic [COLOUR_W-1:0]   out_colour_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign ram_we   = adv && e_ctl.valid && (e_ctl.mode == MODE_WRITE) && e_ctl.keep;
    assign ram_re   = adv && e_ctl.valid && (e_ctl.mode == MODE_READ) && e_ctl.keep;

    pns_map #(
        .SRC_W  (SRC_W),
        .SRC_H  (SRC_H),
        .DST_W  (DST_W),
        .DST_H  (DST_H),
        .ADDR_W (ADDR_W)
    ) u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_x     (s_tdata[8:0]),
        .in_y     (s_tdata[17:9]),
        .in_pix   (s_tdata[25:18]),
        .out_ctl  (e_ctl),
        .out_addr (e_addr),
        .out_idx  (e_idx)
    );

    pns_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (e_addr),
        .wdata (e_idx),
        .re    (ram_re),
        .raddr (e_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg   <= e_ctl.valid && (e_ctl.mode == MODE_READ);
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_zero_reg     <= !e_ctl.keep;
            out_colour_reg <= f_zero_reg ? '0 : to_rgb565(ram_rdata);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_colour_reg;

    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("frame store written and read in one cycle");

    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> f_valid_reg && !f_zero_reg)
        else $error("frame store read without a waiting item");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid_reg && !adv |=> f_valid_reg)
        else $error("read item lost during stall");

    a_border: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && f_valid_reg && f_zero_reg |=> m_tvalid && (m_tdata == '0))
        else $error("border item not black");

endmodule

`default_nettype wire

### test/tb_pns_pkg.sv
// ---------------------------------------------------------------------------
// tb_pns_pkg
// Colour prediction for the palette scaler testbench: its own frame store,
// the nearest-neighbour display mapping and a queue of expected colours.
// ---------------------------------------------------------------------------
`default_nettype none

package tb_pns_pkg;

    localparam int IMG_W       = 256;
    localparam int IMG_H       = 240;
    localparam int DISP_W      = 480;
    localparam int DISP_H      = 320;
    localparam int FIT_W       = IMG_W * DISP_H / IMG_H;
    localparam int LEFT_BORDER = (FIT_W < DISP_W) ? (DISP_W - FIT_W) / 2 : 0;
    localparam int STORE_DEPTH = IMG_W * IMG_H;

    localparam logic [23:0] PALETTE [64] = '{
        24'h666666, 24'h002A88, 24'h1412A7, 24'h3B00A4,
        24'h5C007E, 24'h6E0040, 24'h6C0600, 24'h561D00,
        24'h333500, 24'h0B4800, 24'h005200, 24'h004F08,
        24'h00404D, 24'h000000, 24'h000000, 24'h000000,
        24'hADADAD, 24'h155FD9, 24'h4240FF, 24'h7527FE,
        24'hA01ACC, 24'hB71E7B, 24'hB53120, 24'h994E00,
        24'h6B6D00, 24'h388700, 24'h0C9300, 24'h008F32,
        24'h007C8D, 24'h000000, 24'h000000, 24'h000000,
        24'hFFFEFF, 24'h64B0FF, 24'h9290FF, 24'hC676FF,
        24'hF36AFF, 24'hFF6ECC, 24'hFF8170, 24'hEA9E22,
        24'hBCBE00, 24'h88D800, 24'h5CE430, 24'h45E082,
        24'h48CDDE, 24'h4F4F4F, 24'h000000, 24'h000000,
        24'hFFFEFF, 24'hC0DFFF, 24'hD3D2FF, 24'hE8C8FF,
        24'hFBC2FF, 24'hFEC4EA, 24'hFECCC5, 24'hF7D8A5,
        24'hE4E594, 24'hCFEF96, 24'hBDF4AB, 24'hB3F3CC,
        24'hB5EBF2, 24'hB8B8B8, 24'h000000, 24'h000000
    };

    class pix_scoreboard;

        logic [5:0]  store [STORE_DEPTH];
        logic [15:0] colour_q [$];

        // frame-store address behind a display pixel, -1 for border or off-screen
        function int source_addr(int dx, int dy);
            int ox;
            int sx;
            int sy;
            if (dx >= DISP_W || dy >= DISP_H) return -1;
            if (FIT_W == 0 || dx < LEFT_BORDER) return -1;
            ox = dx - LEFT_BORDER;
            if (ox >= FIT_W) return -1;
            sx = ox * IMG_W / FIT_W;
            sy = dy * IMG_H / DISP_H;
            if (sx >= IMG_W || sy >= IMG_H) return -1;
            return sy * IMG_W + sx;
        endfunction

        function logic [15:0] shade(logic [5:0] idx);
            int r;
            int g;
            int b;
            r = PALETTE[idx][23:16];
            g = PALETTE[idx][15:8];
            b = PALETTE[idx][7:0];
            return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
        endfunction

        function void note_item(logic mode, int x, int y, logic [7:0] pix);
            int a;
            if (mode != pns_pkg::MODE_READ) begin
                if (x < IMG_W && y < IMG_H) store[y * IMG_W + x] = pix[5:0];
            end else begin
                a = source_addr(x, y);
                colour_q.push_back((a < 0) ? 16'h0000 : shade(store[a]));
            end
        endfunction

        function bit check_colour(logic [15:0] got, output string why);
            logic [15:0] want;
            if (colour_q.size() == 0) begin
                why = $sformatf("colour %h with no read outstanding", got);
                return 1'b0;
            end
            want = colour_q.pop_front();
            if (got !== want) begin
                why = $sformatf("colour %h, expected %h", got, want);
                return 1'b0;
            end
            why = "";
            return 1'b1;
        endfunction

        function int pending();
            return colour_q.size();
        endfunction

    endclass

endpackage

`default_nettype wire

### test/tb_palette_nearest_scaler.sv
// ---------------------------------------------------------------------------
// tb_palette_nearest_scaler
// Writes source pixels and reads scaled display pixels through the stream
// ports, predicts every colour and checks each result item in order, under
// phases of sender gaps, receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_palette_nearest_scaler;

    import tb_pns_pkg::*;

    localparam int HANG_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int SEND_PCT [4]    = '{0, 61, 0, 29};
    localparam int RECV_PCT [4]    = '{0, 0, 61, 29};

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pns_pkg::S_DATA_W-1:0]    s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pns_pkg::COLOUR_W-1:0]    m_tdata;

    int errors     = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_req   = 0;

    pix_scoreboard sb = new();

    // entries already written by earlier items, so reads of them are legal
    bit planned [STORE_DEPTH];
    int planned_q [$];

    palette_nearest_scaler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task report_mismatch(string why);
        errors++;
        $display("mismatch at %0t: %s", $time, why);
    endtask

    always @(posedge aclk) begin
        string why;
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[8:0], s_tdata[17:9], s_tdata[25:18]);
        if (aresetn && m_tvalid && m_tready)
            if (!sb.check_colour(m_tdata, why)) report_mismatch(why);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task send_item(logic mode, int x, int y, int pix);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, 8'(pix), 9'(y), 9'(x)};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task idle_until_empty();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task write_pixel(int x, int y, int pix);
        int a;
        if (x < IMG_W && y < IMG_H) begin
            a = y * IMG_W + x;
            if (!planned[a]) planned_q.push_back(a);
            planned[a] = 1'b1;
        end
        send_item(pns_pkg::MODE_WRITE, x, y, pix);
    endtask

    // read a display pixel that lands on the given source entry
    task read_entry(int addr);
        int sx;
        int sy;
        int dx;
        int dy;
        sx = addr % IMG_W;
        sy = addr / IMG_W;
        dx = LEFT_BORDER + (sx * FIT_W + IMG_W - 1) / IMG_W;
        dy = (sy * DISP_H + IMG_H - 1) / IMG_H;
        if ($urandom_range(1) == 1 && sb.source_addr(dx + 1, dy) == addr) dx++;
        if ($urandom_range(1) == 1 && sb.source_addr(dx, dy + 1) == addr) dy++;
        send_item(pns_pkg::MODE_READ, dx, dy, $urandom_range(255));
    endtask

    // a read that would hit an unwritten entry becomes a write of that entry
    task read_display(int dx, int dy);
        int a;
        a = sb.source_addr(dx, dy);
        if (a >= 0 && !planned[a])
            write_pixel(a % IMG_W, a / IMG_W, $urandom_range(255));
        else
            send_item(pns_pkg::MODE_READ, dx, dy, $urandom_range(255));
    endtask

    task random_item();
        int r;
        int x;
        int y;
        r = $urandom_range(99);
        if (r < 40) begin
            x = $urandom_range(IMG_W - 1);
            y = $urandom_range(IMG_H - 1);
            write_pixel(x, y, $urandom_range(255));
            if ($urandom_range(3) == 0) read_entry(y * IMG_W + x);
        end else if (r < 47) begin
            write_pixel($urandom_range(511), $urandom_range(511), $urandom_range(255));
        end else if (r < 85 && planned_q.size() > 0) begin
            read_entry(planned_q[$urandom_range(planned_q.size() - 1)]);
        end else if (r < 93) begin
            read_display($urandom_range(DISP_W - 1), $urandom_range(DISP_H - 1));
        end else begin
            read_display($urandom_range(511), $urandom_range(511));
        end
    endtask

    initial begin
        int p;
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // corners, index masking and ignored writes
        write_pixel(0, 0, 8'hFF);
        write_pixel(IMG_W - 1, IMG_H - 1, 8'h80);
        write_pixel(IMG_W - 1, 0, 8'h7F);
        write_pixel(0, IMG_H - 1, 8'h01);
        write_pixel(IMG_W, 0, 8'h12);
        write_pixel(0, IMG_H, 8'h12);
        write_pixel(511, 511, 8'hFF);
        send_item(pns_pkg::MODE_READ, LEFT_BORDER, 0, 8'hFF);
        read_entry(IMG_W - 1);
        read_entry((IMG_H - 1) * IMG_W);
        read_entry(STORE_DEPTH - 1);
        send_item(pns_pkg::MODE_READ, LEFT_BORDER + FIT_W - 1, DISP_H - 1, 8'h00);
        // border columns either side
        send_item(pns_pkg::MODE_READ, LEFT_BORDER - 1, 0, 8'hAA);
        send_item(pns_pkg::MODE_READ, LEFT_BORDER + FIT_W, 0, 8'h55);
        send_item(pns_pkg::MODE_READ, 0, 0, 8'h00);
        send_item(pns_pkg::MODE_READ, DISP_W - 1, DISP_H - 1, 8'hFF);
        // off-screen reads
        send_item(pns_pkg::MODE_READ, DISP_W, 0, 8'h01);
        send_item(pns_pkg::MODE_READ, 0, DISP_H, 8'h02);
        send_item(pns_pkg::MODE_READ, 511, 511, 8'hFF);
        send_item(pns_pkg::MODE_READ, DISP_W - 1, DISP_H, 8'h80);
        // read straight after write, and an overwrite
        write_pixel(10, 20, 8'h05);
        read_entry(20 * IMG_W + 10);
        write_pixel(0, 0, 8'hCD);
        send_item(pns_pkg::MODE_READ, LEFT_BORDER, 0, 8'h33);
        idle_until_empty();

        for (p = 0; p < 4; p++) begin
            send_idle  = SEND_PCT[p];
            recv_stall = RECV_PCT[p];
            if (p == 0) hold_req = HOLD_CYCLES;
            for (k = 0; k < ITEMS_PER_PHASE; k++) random_item();
            idle_until_empty();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d colours never arrived", sb.pending()));
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### palette_nearest_scaler.f
sv/pns_pkg.sv
sv/pns_ram.sv
sv/pns_map.sv
sv/palette_nearest_scaler.sv
test/tb_pns_pkg.sv
test/tb_palette_nearest_scaler.sv
